// File: src/dts_pkg.sv
// Shared types, constants and helper functions for the duration token scaler.
// Used by the result channel interface, the front end, the token queue, the back end
// and the top level.
package dts_pkg;

   localparam int VALUE_WIDTH_DEF = 64;
   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int DIV_W           = 32;
   localparam int SCALE_W         = 25;
   localparam int CHUNK_W         = 32;
   localparam int STATUS_W        = 3;
   localparam int UNIT_W          = 3;

   localparam logic [DIV_W-1:0] DIVISOR_RESET = 32'd1;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_9   = 8'h39;
   localparam logic [7:0] CH_LS  = 8'h73;
   localparam logic [7:0] CH_LM  = 8'h6d;
   localparam logic [7:0] CH_LH  = 8'h68;
   localparam logic [7:0] CH_LD  = 8'h64;
   localparam logic [7:0] CH_LW  = 8'h77;
   localparam logic [7:0] CH_UM  = 8'h4d;
   localparam logic [7:0] CH_LY  = 8'h79;

   typedef enum logic [UNIT_W-1:0] {
      UNIT_NONE   = 3'd0,
      UNIT_SECOND = 3'd1,
      UNIT_MINUTE = 3'd2,
      UNIT_HOUR   = 3'd3,
      UNIT_DAY    = 3'd4,
      UNIT_WEEK   = 3'd5,
      UNIT_MONTH  = 3'd6,
      UNIT_YEAR   = 3'd7
   } unit_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_NOT_DIGIT = 3'd1,
      STAT_ZERO_DIV  = 3'd2,
      STAT_GARBAGE   = 3'd3,
      STAT_ZERO_VAL  = 3'd4,
      STAT_TRUNCATE  = 3'd5
   } status_type;

   // Per-token flags handed from the front end to the back end.
   typedef struct packed {
      logic     bad_first;
      logic     bad_suffix;
      unit_type unit_sel;
   } token_flags_type;

   localparam int FLAGS_W = $bits(token_flags_type);

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_0) && (c <= CH_9);
   endfunction

   function automatic unit_type suffix_code(input logic [7:0] c);
      unit_type u;
      case (c)
         CH_LS:   u = UNIT_SECOND;
         CH_LM:   u = UNIT_MINUTE;
         CH_LH:   u = UNIT_HOUR;
         CH_LD:   u = UNIT_DAY;
         CH_LW:   u = UNIT_WEEK;
         CH_UM:   u = UNIT_MONTH;
         CH_LY:   u = UNIT_YEAR;
         default: u = UNIT_NONE;
      endcase
      return u;
   endfunction

   function automatic logic [SCALE_W-1:0] unit_scale(input unit_type u);
      logic [SCALE_W-1:0] s;
      case (u)
         UNIT_NONE:   s = 25'd1;
         UNIT_SECOND: s = 25'd1;
         UNIT_MINUTE: s = 25'd60;
         UNIT_HOUR:   s = 25'd3600;
         UNIT_DAY:    s = 25'd86400;
         UNIT_WEEK:   s = 25'd604800;
         UNIT_MONTH:  s = 25'd2678400;
         UNIT_YEAR:   s = 25'd31622400;
         default:     s = 25'd1;
      endcase
      return s;
   endfunction

endpackage

// File: src/dts_req_if.sv
// Character channel of the duration token scaler: valid/ready plus one character.
// Depends on nothing.
interface dts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

// File: src/dts_rsp_if.sv
// Result channel of the duration token scaler: valid/ready plus status and value.
// Depends on dts_pkg for the status width and the default value width.
interface dts_rsp_if
   import dts_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output status, output value, input ready);
   modport sink   (input valid, input status, input value, output ready);
endinterface

// File: src/dts_queue.sv
// Short register FIFO that carries finished token records from front to back.
// Depends on dts_pkg only for its default depth.
module dts_queue
   import dts_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/dts_front.sv
// Character front end: parses digits and the unit suffix one item per cycle while
// the queue is not full, holds the divisor register and emits one token record at each NUL.
// Depends on dts_pkg and dts_req_if.
module dts_front
   import dts_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   dts_req_if.sink                req_if,
   input  logic                   csr_we,
   input  logic [DIV_W-1:0]       csr_wdata,
   input  logic                   q_full,
   output logic                   rec_push,
   output token_flags_type        rec_flags,
   output logic [DIV_W-1:0]       rec_divisor,
   output logic [VALUE_WIDTH-1:0] rec_accum
);

   typedef enum logic [2:0] {
      PH_FIRST  = 3'b001,
      PH_DIGITS = 3'b010,
      PH_SKIP   = 3'b100
   } phase_type;

   localparam logic [VALUE_WIDTH-1:0] VAL_MAX = '1;

   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] accum_ff, accum_in;
   unit_type               unit_ff, unit_in;
   logic                   bad_first_ff, bad_first_in;
   logic                   bad_suffix_ff, bad_suffix_in;
   logic [DIV_W-1:0]       divisor_ff, divisor_in;

   logic                   accept;
   logic                   digit;
   logic [3:0]             digit_val;
   logic [VALUE_WIDTH+3:0] times_ten;
   unit_type               code;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign digit        = is_digit(req_if.ch);
   assign digit_val    = 4'(req_if.ch - CH_0);
   assign code         = suffix_code(req_if.ch);

   // Anything that spills above the value width means the count has saturated.
   assign times_ten = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                      + (VALUE_WIDTH + 4)'(digit_val);

   assign rec_push              = accept && (req_if.ch == CH_NUL);
   assign rec_flags.bad_first   = bad_first_ff || (phase_ff == PH_FIRST);
   assign rec_flags.bad_suffix  = bad_suffix_ff;
   assign rec_flags.unit_sel    = unit_ff;
   assign rec_divisor           = divisor_ff;
   assign rec_accum             = accum_ff;

   always_comb begin
      phase_in      = phase_ff;
      accum_in      = accum_ff;
      unit_in       = unit_ff;
      bad_first_in  = bad_first_ff;
      bad_suffix_in = bad_suffix_ff;
      divisor_in    = csr_we ? csr_wdata : divisor_ff;
      if (accept) begin
         if (req_if.ch == CH_NUL) begin
            phase_in      = PH_FIRST;
            accum_in      = '0;
            unit_in       = UNIT_NONE;
            bad_first_in  = 1'b0;
            bad_suffix_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_FIRST: begin
                  if (digit) begin
                     accum_in = VALUE_WIDTH'(digit_val);
                     phase_in = PH_DIGITS;
                  end else begin
                     bad_first_in = 1'b1;
                     phase_in     = PH_SKIP;
                  end
               end
               PH_DIGITS: begin
                  if (digit) begin
                     accum_in = (times_ten[VALUE_WIDTH+3:VALUE_WIDTH] != 4'd0)
                                ? VAL_MAX : times_ten[VALUE_WIDTH-1:0];
                  end else begin
                     unit_in       = code;
                     bad_suffix_in = (code == UNIT_NONE);
                     phase_in      = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  phase_in = PH_SKIP;
               end
               default: begin
                  phase_in = PH_SKIP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         accum_ff      <= '0;
         unit_ff       <= UNIT_NONE;
         bad_first_ff  <= 1'b0;
         bad_suffix_ff <= 1'b0;
         divisor_ff    <= DIVISOR_RESET;
      end else begin
         phase_ff      <= phase_in;
         accum_ff      <= accum_in;
         unit_ff       <= unit_in;
         bad_first_ff  <= bad_first_in;
         bad_suffix_ff <= bad_suffix_in;
         divisor_ff    <= divisor_in;
      end
   end

endmodule

// File: src/dts_back.sv
// Token back end: scales the count by the unit with a chunked multiplier, checks it,
// if a unit is set, divides by the divisor one quotient bit per cycle, then registers it.
// Depends on dts_pkg and dts_rsp_if.
module dts_back
   import dts_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  token_flags_type        q_flags,
   input  logic [DIV_W-1:0]       q_divisor,
   input  logic [VALUE_WIDTH-1:0] q_accum,
   output logic                   q_pop,
   dts_rsp_if.source              rsp_if
);

   localparam int NCHUNK = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
   localparam int IDX_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PP_W   = CHUNK_W + SCALE_W;
   localparam int SH_W   = NCHUNK * CHUNK_W + PP_W;
   localparam int CNT_W  = $clog2(VALUE_WIDTH);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_ADD   = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_DIV   = 7'b0010000,
      ST_FIN   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } back_state_type;

   back_state_type          state_ff, state_in;
   logic [VALUE_WIDTH-1:0]  accum_ff, accum_in;
   unit_type                unit_ff, unit_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [PP_W-1:0]         pp_ff, pp_in;
   logic [VALUE_WIDTH-1:0]  prod_ff, prod_in;
   logic [VALUE_WIDTH-1:0]  quo_ff, quo_in;
   logic [DIV_W-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   status_type              res_status_ff, res_status_in;
   logic [VALUE_WIDTH-1:0]  res_value_ff, res_value_in;
   logic                    out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [VALUE_WIDTH-1:0]  out_value_ff, out_value_in;

   logic [NCHUNK*CHUNK_W-1:0] acc_pad;
   logic [CHUNK_W-1:0]        chunk;
   logic [SH_W-1:0]           pp_shift;
   logic [DIV_W:0]            rem_sh;
   logic                      rem_ge;
   logic                      out_free;

   assign acc_pad  = (NCHUNK * CHUNK_W)'(accum_ff);
   assign chunk    = CHUNK_W'(acc_pad >> {idx_ff, 5'b00000});
   assign pp_shift = SH_W'(pp_ff) << {idx_ff, 5'b00000};
   assign rem_sh   = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign rem_ge   = (rem_sh >= {1'b0, div_ff});
   assign out_free = !out_valid_ff || rsp_if.ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   assign rsp_if.valid  = out_valid_ff;
   assign rsp_if.status = out_status_ff;
   assign rsp_if.value  = out_value_ff;

   always_comb begin
      state_in      = state_ff;
      accum_in      = accum_ff;
      unit_in       = unit_ff;
      div_in        = div_ff;
      idx_in        = idx_ff;
      pp_in         = pp_ff;
      prod_in       = prod_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      out_valid_in  = out_valid_ff && !rsp_if.ready;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               accum_in     = q_accum;
               unit_in      = q_flags.unit_sel;
               div_in       = q_divisor;
               idx_in       = '0;
               prod_in      = '0;
               res_value_in = '0;
               if (q_flags.bad_first) begin
                  res_status_in = STAT_NOT_DIGIT;
                  state_in      = ST_EMIT;
               end else if (q_divisor == '0) begin
                  res_status_in = STAT_ZERO_DIV;
                  state_in      = ST_EMIT;
               end else if (q_flags.bad_suffix) begin
                  res_status_in = STAT_GARBAGE;
                  state_in      = ST_EMIT;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            pp_in    = chunk * unit_scale(unit_ff);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // Partial products above the value width drop out: the scaling wraps.
            prod_in = prod_ff + pp_shift[VALUE_WIDTH-1:0];
            if (idx_ff == IDX_W'(NCHUNK - 1)) begin
               state_in = ST_CHECK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_CHECK: begin
            if (prod_ff == '0) begin
               res_status_in = STAT_ZERO_VAL;
               res_value_in  = '0;
               state_in      = ST_EMIT;
            end else if (unit_ff == UNIT_NONE) begin
               res_status_in = STAT_OK;
               res_value_in  = prod_ff;
               state_in      = ST_EMIT;
            end else begin
               quo_in   = prod_ff;
               rem_in   = '0;
               cnt_in   = CNT_W'(VALUE_WIDTH - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_ge ? DIV_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DIV_W-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], rem_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rem_ff == '0) begin
               res_status_in = STAT_OK;
               res_value_in  = quo_ff;
            end else begin
               res_status_in = STAT_TRUNCATE;
               res_value_in  = '0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_value_in  = res_value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accum_ff      <= accum_in;
      unit_ff       <= unit_in;
      div_ff        <= div_in;
      idx_ff        <= idx_in;
      pp_ff         <= pp_in;
      prod_ff       <= prod_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
   end

endmodule

// File: src/duration_token_scaler.sv
// Duration token scaler: the front end takes one character item per cycle while the
// queue has room; each token's record waits in a QUEUE_DEPTH-entry queue (two by
// default) for the back end. The back end takes a new token only once it has emitted
// the last one; with a unit set, its one-bit-per-cycle divider bounds throughput per token.
// Synchronous active-high reset clears the parser, queue and result; divisor resets to 1.
module duration_token_scaler
   import dts_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   dts_req_if.sink          req_if,
   dts_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [DIV_W-1:0] csr_wdata
);

   localparam int REC_W = FLAGS_W + DIV_W + VALUE_WIDTH;

   logic                   q_full;
   logic                   q_not_empty;
   logic                   q_pop;
   logic                   rec_push;
   token_flags_type        rec_flags;
   logic [DIV_W-1:0]       rec_divisor;
   logic [VALUE_WIDTH-1:0] rec_accum;
   logic [REC_W-1:0]       push_data;
   logic [REC_W-1:0]       pop_data;
   token_flags_type        q_flags;
   logic [DIV_W-1:0]       q_divisor;
   logic [VALUE_WIDTH-1:0] q_accum;

   assign push_data = {rec_flags, rec_divisor, rec_accum};
   assign {q_flags, q_divisor, q_accum} = pop_data;

   dts_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .rec_push    (rec_push),
      .rec_flags   (rec_flags),
      .rec_divisor (rec_divisor),
      .rec_accum   (rec_accum)
   );

   dts_queue #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .not_empty (q_not_empty)
   );

   dts_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_flags   (q_flags),
      .q_divisor (q_divisor),
      .q_accum   (q_accum),
      .q_pop     (q_pop),
      .rsp_if    (rsp_if)
   );

endmodule
